// File: design/yps_pkg.sv
// Package for the YUV packet stream to RGB converter.
// Holds widths, register indexes, format codes, queue word type and coefficient ROMs.
// No dependencies.
package yps_pkg;

    localparam int FRAC_BITS        = 10;
    localparam int MAX_PACKET_BYTES = 4096;

    localparam int PB_W   = 13;
    localparam int GPP_W  = $clog2(MAX_PACKET_BYTES / 3 + 1);
    localparam int TERM_W = FRAC_BITS + 10;
    localparam int SUM_W  = FRAC_BITS + 11;

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT  = 2'd0;
    localparam logic [1:0] CFG_STRIP_HEADERS = 2'd1;
    localparam logic [1:0] CFG_PACKET_BYTES  = 2'd2;

    // pixel format codes
    localparam logic [1:0] FMT_422 = 2'd0;
    localparam logic [1:0] FMT_444 = 2'd1;
    localparam logic [1:0] FMT_411 = 2'd2;

    localparam logic [2:0] GLEN_422 = 3'd4;
    localparam logic [2:0] GLEN_444 = 3'd3;
    localparam logic [2:0] GLEN_411 = 3'd6;

    localparam logic [3:0] HDR_SKIP     = 4'd4;
    localparam logic [3:0] TRAILER_SKIP = 4'd7;
    localparam int         STRIP_BYTES  = 8;

    // floor(x/3) = (x * RECIP3) >> RECIP3_SH for x below 2^16
    localparam int RECIP3    = 43691;
    localparam int RECIP3_SH = 17;

    localparam int PB_RESET = 1024;
    localparam logic [GPP_W-1:0] GPP_RESET = GPP_W'((PB_RESET - STRIP_BYTES) / 4);

    localparam int K_Y  = 1164;
    localparam int K_RV = 1596;
    localparam int K_GV = -813;
    localparam int K_GU = -391;
    localparam int K_BU = 2018;

    typedef struct packed {
        logic [1:0]    pixel_format;
        logic          strip_headers;
        logic [PB_W-1:0] packet_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] u;
        logic [7:0] v;
        logic       last;
    } pix_req_t;

    typedef struct packed {
        logic     wr0;
        logic     wr1;
        pix_req_t req0;
        pix_req_t req1;
    } queue_wr_t;

    typedef logic signed [TERM_W-1:0] term_tab_t [256];

    function automatic term_tab_t build_tab(input int k, input bit luma);
        term_tab_t t;
        longint    d;
        longint    p;
        int        i;
        for (i = 0; i < 256; i++)
        begin
            if (luma)
                d = (i > 16) ? longint'(i - 16) : 64'sd0;
            else
                d = longint'(i - 128);
            p = longint'(k) * d * (longint'(1) <<< FRAC_BITS);
            if (p < 0)
                p = -((-p) / 1000);
            else
                p = p / 1000;
            t[i] = TERM_W'(p);
        end
        return t;
    endfunction

    localparam term_tab_t Y_TAB  = build_tab(K_Y, 1'b1);
    localparam term_tab_t RV_TAB = build_tab(K_RV, 1'b0);
    localparam term_tab_t GV_TAB = build_tab(K_GV, 1'b0);
    localparam term_tab_t GU_TAB = build_tab(K_GU, 1'b0);
    localparam term_tab_t BU_TAB = build_tab(K_BU, 1'b0);

endpackage

// File: design/yps_if.sv
// Stream interfaces: raw byte words in, RGB pixel words out.
// Depends on yps_pkg.
interface yps_in_if import yps_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_start;

    modport source (output valid, output data_byte, output buffer_start, input ready);
    modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

interface yps_out_if import yps_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;

    modport source (output valid, output red, output green, output blue,
                    output last_of_run, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_of_run, output ready);
endinterface

// File: design/yps_front.sv
// Front end: header stripping, group unpacking, pixel request generation.
// Depends on yps_pkg and yps_in_if.
module yps_front import yps_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  logic           room,
    yps_in_if.sink         in_ch,
    output queue_wr_t      qwr
);

    logic [2:0]       phase_reg, phase_next;
    logic [GPP_W-1:0] gd_reg, gd_next;
    logic [3:0]       skip_reg, skip_next;
    logic [7:0]       u_reg, u_next;
    logic [7:0]       v_reg, v_next;
    logic [7:0]       l0_reg, l0_next;
    logic [7:0]       l1_reg, l1_next;
    logic [GPP_W-1:0] gpp_reg, gpp_next;

    logic [1:0]       fmt;
    logic [2:0]       glen;
    logic [PB_W-1:0]  size;
    logic [PB_W-1:0]  payload;
    logic [PB_W+16:0] prod3;
    logic [PB_W-1:0]  div3;

    logic             accept;
    logic [2:0]       ph;
    logic [2:0]       ph_inc;
    logic [GPP_W-1:0] gd;
    logic [3:0]       sk;
    logic             go;
    logic [7:0]       b;

    assign accept      = in_ch.valid & in_ch.ready;
    assign in_ch.ready = room;
    assign b           = in_ch.data_byte;

    always_comb
    begin
        unique case (cfg.pixel_format)
            FMT_444: begin fmt = FMT_444; glen = GLEN_444; end
            FMT_411: begin fmt = FMT_411; glen = GLEN_411; end
            default: begin fmt = FMT_422; glen = GLEN_422; end
        endcase
    end

    // whole groups per packet
    always_comb
    begin
        size = ({1'b0, cfg.packet_bytes} > (PB_W + 1)'(MAX_PACKET_BYTES))
             ? PB_W'(MAX_PACKET_BYTES) : cfg.packet_bytes;
        if (cfg.strip_headers)
            payload = (size > PB_W'(STRIP_BYTES)) ? size - PB_W'(STRIP_BYTES) : '0;
        else
            payload = size;
        prod3 = (PB_W + 17)'(payload) * (PB_W + 17)'(RECIP3);
        div3  = PB_W'(prod3 >> RECIP3_SH);
        unique case (fmt)
            FMT_444: gpp_next = GPP_W'(div3);
            FMT_411: gpp_next = GPP_W'(div3 >> 1);
            default: gpp_next = GPP_W'(payload >> 2);
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        gd_next    = gd_reg;
        skip_next  = skip_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        l0_next    = l0_reg;
        l1_next    = l1_reg;
        qwr        = '0;
        ph         = phase_reg;
        gd         = gd_reg;
        sk         = skip_reg;
        go         = 1'b0;
        ph_inc     = '0;

        if (accept)
        begin
            if (in_ch.buffer_start)
            begin
                ph = '0;
                gd = '0;
                sk = cfg.strip_headers ? HDR_SKIP : 4'd0;
            end
            if (sk != 4'd0)
            begin
                skip_next  = sk - 4'd1;
                phase_next = ph;
                gd_next    = gd;
            end
            else
            begin
                go        = 1'b1;
                skip_next = sk;
                if (ph >= glen)
                    ph = '0;
                if (ph == 3'd0 && gd >= gpp_reg)
                begin
                    gd = '0;
                    if (cfg.strip_headers)
                    begin
                        skip_next = TRAILER_SKIP;
                        go        = 1'b0;
                    end
                    else if (gpp_reg == '0)
                        go = 1'b0;
                end
                phase_next = ph;
                gd_next    = gd;

                if (go)
                begin
                    if (ph == 3'd0)
                        u_next = b;
                    else if (fmt == FMT_411)
                    begin
                        unique case (ph)
                            3'd1: l0_next = b;
                            3'd2: l1_next = b;
                            3'd3:
                            begin
                                v_next   = b;
                                qwr.wr0  = 1'b1;
                                qwr.req0 = '{luma: l0_reg, u: u_reg, v: b, last: 1'b0};
                                qwr.wr1  = 1'b1;
                                qwr.req1 = '{luma: l1_reg, u: u_reg, v: b, last: 1'b1};
                            end
                            default:
                            begin
                                qwr.wr0  = 1'b1;
                                qwr.req0 = '{luma: b, u: u_reg, v: v_reg, last: 1'b1};
                            end
                        endcase
                    end
                    else
                    begin
                        unique case (ph)
                            3'd1: l0_next = b;
                            3'd2:
                            begin
                                v_next   = b;
                                qwr.wr0  = 1'b1;
                                qwr.req0 = '{luma: l0_reg, u: u_reg, v: b, last: 1'b1};
                            end
                            default:
                            begin
                                qwr.wr0  = 1'b1;
                                qwr.req0 = '{luma: b, u: u_reg, v: v_reg, last: 1'b1};
                            end
                        endcase
                    end

                    ph_inc = ph + 3'd1;
                    if (ph_inc >= glen)
                    begin
                        phase_next = '0;
                        gd_next    = gd + GPP_W'(1);
                    end
                    else
                        phase_next = ph_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            gd_reg    <= '0;
            skip_reg  <= HDR_SKIP;
            u_reg     <= '0;
            v_reg     <= '0;
            l0_reg    <= '0;
            l1_reg    <= '0;
            gpp_reg   <= GPP_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            gd_reg    <= gd_next;
            skip_reg  <= skip_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            l0_reg    <= l0_next;
            l1_reg    <= l1_next;
            gpp_reg   <= gpp_next;
        end
    end

endmodule

// File: design/yps_queue.sv
// Short request queue between front end and converter; takes up to two words a cycle.
// Depends on yps_pkg.
module yps_queue import yps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  queue_wr_t qwr,
    output logic      room,
    output logic      rd_valid,
    output pix_req_t  rd_data,
    input  logic      pop
);

    pix_req_t          mem_reg [QDEPTH];
    logic [QA_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QA_W:0]     count_reg, count_next;
    logic [QA_W-1:0]   wr_ptr_p1;

    assign room      = count_reg <= (QA_W + 1)'(QDEPTH - 2);
    assign rd_valid  = count_reg != '0;
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + QA_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QA_W'(qwr.wr0) + QA_W'(qwr.wr1);
        rd_ptr_next = rd_ptr_reg + QA_W'(pop);
        count_next  = count_reg + (QA_W + 1)'(qwr.wr0) + (QA_W + 1)'(qwr.wr1)
                    - (QA_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (qwr.wr0)
            mem_reg[wr_ptr_reg] <= qwr.req0;
        if (qwr.wr1)
            mem_reg[wr_ptr_p1] <= qwr.req1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/yps_conv.sv
// Converter: ROM lookup stage, then sum, shift and clamp into the output register.
// Depends on yps_pkg and yps_out_if.
module yps_conv import yps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_valid,
    input  pix_req_t   rd_data,
    output logic       pop,
    yps_out_if.source  out_ch
);

    logic                     s1_v_reg, s1_v_next;
    logic signed [TERM_W-1:0] ty_reg, rv_reg, gv_reg, gu_reg, bu_reg;
    logic                     s1_last_reg;

    logic                     o_v_reg, o_v_next;
    logic [7:0]               red_reg, green_reg, blue_reg;
    logic                     last_reg;

    logic                     s1_load;
    logic                     o_load;
    logic signed [SUM_W-1:0]  r_sum, g_sum, b_sum;

    function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = s >>> FRAC_BITS;
        if (q < 0)
            return 8'd0;
        else if (q > SUM_W'(255))
            return 8'd255;
        else
            return q[7:0];
    endfunction

    assign o_load  = !o_v_reg || out_ch.ready;
    assign s1_load = !s1_v_reg || o_load;
    assign pop     = rd_valid && s1_load;

    assign s1_v_next = s1_load ? rd_valid : s1_v_reg;
    assign o_v_next  = o_load ? s1_v_reg : o_v_reg;

    assign r_sum = SUM_W'(ty_reg) + SUM_W'(rv_reg);
    assign g_sum = SUM_W'(ty_reg) + SUM_W'(gv_reg) + SUM_W'(gu_reg);
    assign b_sum = SUM_W'(ty_reg) + SUM_W'(bu_reg);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ty_reg      <= Y_TAB[rd_data.luma];
            rv_reg      <= RV_TAB[rd_data.v];
            gv_reg      <= GV_TAB[rd_data.v];
            gu_reg      <= GU_TAB[rd_data.u];
            bu_reg      <= BU_TAB[rd_data.u];
            s1_last_reg <= rd_data.last;
        end
        if (o_load && s1_v_reg)
        begin
            red_reg   <= clamp8(r_sum);
            green_reg <= clamp8(g_sum);
            blue_reg  <= clamp8(b_sum);
            last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            o_v_reg  <= o_v_next;
        end
    end

    assign out_ch.valid       = o_v_reg;
    assign out_ch.red         = red_reg;
    assign out_ch.green       = green_reg;
    assign out_ch.blue        = blue_reg;
    assign out_ch.last_of_run = last_reg;

endmodule

// File: design/yuv_packet_stream_to_rgb.sv
// YUV packet byte stream to RGB pixel converter, top level.
// Path: the byte that completes a pixel writes its request into the queue; the request then
// passes the ROM lookup register and the output register (in a 4:1:1 pair, after the first).
// Throughput: one byte per cycle while the 4-word request queue has two free slots, except
// that input is held in the cycle after each config write; the converter delivers one pixel
// per cycle unless the output stalls, so the queue stalls input only on output stall.
// Reset: async active low; clears unpacking state and queue, config to 4:2:2, stripping on,
// 1024-byte packets.
module yuv_packet_stream_to_rgb import yps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [PB_W-1:0] cfg_data,
    yps_in_if.sink          in_ch,
    yps_out_if.source       out_ch
);

    logic [1:0]      pixel_format_reg;
    logic            strip_headers_reg;
    logic [PB_W-1:0] packet_bytes_reg;
    logic            cfg_hold_reg;

    cfg_t       cfg;
    queue_wr_t  qwr;
    logic       room;
    logic       front_room;
    logic       rd_valid;
    pix_req_t   rd_data;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg  <= FMT_422;
            strip_headers_reg <= 1'b1;
            packet_bytes_reg  <= PB_W'(PB_RESET);
            cfg_hold_reg      <= 1'b0;
        end
        else
        begin
            cfg_hold_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PIXEL_FORMAT:  pixel_format_reg  <= cfg_data[1:0];
                    CFG_STRIP_HEADERS: strip_headers_reg <= cfg_data[0];
                    CFG_PACKET_BYTES:  packet_bytes_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign cfg.pixel_format  = pixel_format_reg;
    assign cfg.strip_headers = strip_headers_reg;
    assign cfg.packet_bytes  = packet_bytes_reg;

    // groups per packet is registered in the front end; hold input while it updates
    assign front_room = room && !cfg_hold_reg;

    yps_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .room  (front_room),
        .in_ch (in_ch),
        .qwr   (qwr)
    );

    yps_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .qwr      (qwr),
        .room     (room),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .pop      (pop)
    );

    yps_conv u_conv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule
